FILE: design/plateau_and_best_tracker_unit_defines.svh
// assertion helpers for the plateau and best tracker checker
// they expect clk and arst_n in scope
`ifndef PLATEAU_AND_BEST_TRACKER_UNIT_DEFINES_SVH
`define PLATEAU_AND_BEST_TRACKER_UNIT_DEFINES_SVH

// consequent checked in the same cycle
`define PTRK_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define PTRK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/ptrk_pkg.sv
`default_nettype none

package ptrk_pkg;

	localparam int unsigned METRIC_W = 32;
	localparam int unsigned STEP_W   = 32;
	localparam int unsigned STALL_W  = 32;
	localparam int unsigned MARGIN_W = 31;
	localparam int unsigned WLEN_W   = 7;

	// config port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 31;

	localparam logic [CFG_IDX_W-1:0] REG_IMPROVE_MARGIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 2'd1;

	typedef logic signed [METRIC_W-1:0] metric_t;
	typedef logic [STEP_W-1:0]          step_t;
	typedef logic [STALL_W-1:0]         stall_t;

	// best metric before any item: largest positive value
	localparam metric_t BEST_RESET = {1'b0, {(METRIC_W-1){1'b1}}};

endpackage

`default_nettype wire

FILE: design/ptrk_if.sv
`default_nettype none

interface ptrk_in_if;
	logic              valid;
	logic              ready;
	ptrk_pkg::step_t   eval_step;
	ptrk_pkg::metric_t metric_value;

	modport source(output valid, output eval_step, output metric_value, input ready);
	modport sink(input valid, input eval_step, input metric_value, output ready);
endinterface

interface ptrk_out_if;
	logic              valid;
	logic              ready;
	logic              plateau_reached;
	logic              new_best;
	ptrk_pkg::metric_t best_metric;
	ptrk_pkg::step_t   best_at_step;
	ptrk_pkg::stall_t  evals_without_gain;

	modport source(output valid, output plateau_reached, output new_best,
		output best_metric, output best_at_step, output evals_without_gain, input ready);
	modport sink(input valid, input plateau_reached, input new_best,
		input best_metric, input best_at_step, input evals_without_gain, output ready);
endinterface

`default_nettype wire

FILE: design/plateau_and_best_tracker_unit.sv
// Tracks the best (lowest) signed Q16.16 metric, its step and a saturating count of
// evaluations without gain, and flags a plateau when the least-squares slope over the
// last window_length metrics (capped at WINDOW_MAX) is zero or rising. One result beat
// per input beat. An item without a full window of at least two metrics goes from the
// accept through ST_FIN into the output register; otherwise it first passes through
// ST_CALC, where the single shared multiply-accumulate walks the metric memory one entry
// per cycle through its one read port. The input is not ready while an item is being
// worked on; a finished result may wait in the output register while the next beat is
// taken. Writing window_length restarts the window fill.
`default_nettype none

module plateau_and_best_tracker_unit #(
	parameter int unsigned WINDOW_MAX = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	ptrk_in_if.sink                                  eval_in,
	ptrk_out_if.source                               result_out,
	input  wire logic                                cfg_we,
	input  wire logic [ptrk_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ptrk_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int unsigned AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int unsigned CW    = $clog2(WINDOW_MAX + 1);
	localparam int unsigned WW    = AW + 1;
	localparam int unsigned PW    = ptrk_pkg::METRIC_W + WW;
	localparam int unsigned ACC_W = 2 * AW + 33;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]                       state_q;
	logic [ptrk_pkg::MARGIN_W-1:0]    improve_margin_q;
	logic [ptrk_pkg::WLEN_W-1:0]      window_length_q;
	logic [CW-1:0]                    fill_q;
	logic [AW-1:0]                    oldest_q;
	ptrk_pkg::metric_t                best_q;
	ptrk_pkg::step_t                  best_step_q;
	ptrk_pkg::stall_t                 stall_q;
	logic                             gained_q;
	logic                             do_fit_q;
	logic [AW-1:0]                    rd_addr_q;
	logic signed [WW-1:0]             weight_q;
	logic [CW-1:0]                    left_q;
	logic signed [ACC_W-1:0]          acc_q;
	logic                             v_s1;
	logic                             v_s2;
	ptrk_pkg::metric_t                rd_s1;
	logic signed [WW-1:0]             w_s1;
	logic signed [PW-1:0]             prod_s2;

	logic                             out_valid_q;
	logic                             out_plateau_q;
	logic                             out_new_best_q;
	ptrk_pkg::metric_t                out_best_q;
	ptrk_pkg::step_t                  out_step_q;
	ptrk_pkg::stall_t                 out_stall_q;

	ptrk_pkg::metric_t                mem [WINDOW_MAX];

	logic                             in_fire;
	logic                             out_load;
	logic signed [33:0]               metric_x;
	logic signed [33:0]               thresh_x;
	logic                             gained;
	logic [CW-1:0]                    n_w;
	logic [CW-1:0]                    fill_nx;
	logic [AW-1:0]                    oldest_nx;
	logic [CW-1:0]                    oldest_ext;
	logic [AW-1:0]                    start_w;
	logic                             do_fit;
	logic                             calc_done;

	assign eval_in.ready = (state_q == ST_IDLE);
	assign in_fire       = eval_in.valid && eval_in.ready;
	assign out_load      = (state_q == ST_FIN) && (!out_valid_q || result_out.ready);

	always_comb begin
		metric_x = {{2{eval_in.metric_value[31]}}, eval_in.metric_value};
		thresh_x = {{2{best_q[31]}}, best_q} - {3'b000, improve_margin_q};
		gained   = metric_x < thresh_x;

		if (32'(window_length_q) > WINDOW_MAX) begin
			n_w = CW'(WINDOW_MAX);
		end else begin
			n_w = CW'(window_length_q);
		end

		fill_nx    = (fill_q == CW'(WINDOW_MAX)) ? fill_q : fill_q + 1'b1;
		oldest_nx  = (oldest_q == AW'(WINDOW_MAX - 1)) ? '0 : oldest_q + 1'b1;
		oldest_ext = CW'(oldest_nx);
		// oldest of the last n entries, wrapping around the ring
		if (oldest_ext >= n_w) begin
			start_w = AW'(oldest_ext - n_w);
		end else begin
			start_w = AW'(oldest_ext + CW'(WINDOW_MAX) - n_w);
		end
		do_fit    = (n_w >= CW'(2)) && (fill_nx >= n_w);
		calc_done = (left_q == '0) && !v_s1 && !v_s2;
	end

	// metric ring
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mem[oldest_q] <= eval_in.metric_value;
		end
		rd_s1   <= mem[rd_addr_q];
		w_s1    <= weight_q;
		prod_s2 <= PW'(rd_s1) * PW'(w_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			improve_margin_q <= '0;
			window_length_q  <= '0;
			fill_q           <= '0;
			oldest_q         <= '0;
			best_q           <= ptrk_pkg::BEST_RESET;
			best_step_q      <= '0;
			stall_q          <= '0;
			gained_q         <= 1'b0;
			do_fit_q         <= 1'b0;
			rd_addr_q        <= '0;
			weight_q         <= '0;
			left_q           <= '0;
			acc_q            <= '0;
			v_s1             <= 1'b0;
			v_s2             <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ptrk_pkg::REG_IMPROVE_MARGIN: begin
						improve_margin_q <= cfg_data;
					end
					ptrk_pkg::REG_WINDOW_LENGTH: begin
						window_length_q <= cfg_data[ptrk_pkg::WLEN_W-1:0];
						fill_q          <= '0;
						oldest_q        <= '0;
					end
					default: begin
					end
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						gained_q  <= gained;
						do_fit_q  <= do_fit;
						if (gained) begin
							best_q      <= eval_in.metric_value;
							best_step_q <= eval_in.eval_step;
							stall_q     <= '0;
						end else if (stall_q != '1) begin
							stall_q <= stall_q + 1'b1;
						end
						fill_q    <= fill_nx;
						oldest_q  <= oldest_nx;
						rd_addr_q <= start_w;
						weight_q  <= WW'(1) - WW'(n_w);
						left_q    <= do_fit ? n_w : '0;
						acc_q     <= '0;
						state_q   <= do_fit ? ST_CALC : ST_FIN;
					end
				end
				ST_CALC: begin
					v_s1 <= (left_q != '0);
					v_s2 <= v_s1;
					if (left_q != '0) begin
						left_q    <= left_q - 1'b1;
						weight_q  <= weight_q + WW'(2);
						rd_addr_q <= (rd_addr_q == AW'(WINDOW_MAX - 1)) ? '0 : rd_addr_q + 1'b1;
					end
					if (v_s2) begin
						acc_q <= acc_q + ACC_W'(prod_s2);
					end
					if (calc_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_plateau_q  <= do_fit_q && !acc_q[ACC_W-1];
			out_new_best_q <= gained_q;
			out_best_q     <= best_q;
			out_step_q     <= best_step_q;
			out_stall_q    <= stall_q;
		end
	end

	assign result_out.valid              = out_valid_q;
	assign result_out.plateau_reached    = out_plateau_q;
	assign result_out.new_best           = out_new_best_q;
	assign result_out.best_metric        = out_best_q;
	assign result_out.best_at_step       = out_step_q;
	assign result_out.evals_without_gain = out_stall_q;

endmodule

`default_nettype wire

FILE: design/ptrk_checker.sv
`default_nettype none
`include "plateau_and_best_tracker_unit_defines.svh"

module ptrk_checker (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_ready,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic                   new_best,
	input wire ptrk_pkg::stall_t       evals_without_gain
);

	`PTRK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")
	`PTRK_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready while busy")
	`PTRK_ASSERT_SAME(a_best_resets_stall, out_valid, new_best == (evals_without_gain == '0), "stall count out of step with new best")

endmodule

bind plateau_and_best_tracker_unit ptrk_checker u_ptrk_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (eval_in.valid),
	.in_ready           (eval_in.ready),
	.out_valid          (result_out.valid),
	.out_ready          (result_out.ready),
	.new_best           (result_out.new_best),
	.evals_without_gain (result_out.evals_without_gain)
);

`default_nettype wire

FILE: dv/tb_plateau_and_best_tracker_unit.sv
`default_nettype none

module tb_plateau_and_best_tracker_unit;
	import ptrk_pkg::*;

	localparam int unsigned WIN_DEPTH     = 64;
	localparam int unsigned ITEM_GOAL     = 720;
	localparam int unsigned QUIET_TAIL    = 60;
	localparam int unsigned SETTLE_CYCLES = 80;
	localparam int unsigned HOLD_CYCLES   = 400;

	// indexes that map to no register
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		logic    plateau_reached;
		logic    new_best;
		metric_t best_metric;
		step_t   best_at_step;
		stall_t  evals_without_gain;
	} tracker_result_t;

	typedef enum logic {ROW_EVAL, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		step_t                 st;
		metric_t               m;
		logic                  typed;
		tracker_result_t       want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ptrk_in_if  ev_ch();
	ptrk_out_if res_ch();

	plateau_and_best_tracker_unit #(.WINDOW_MAX(WIN_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.eval_in(ev_ch),
		.result_out(res_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	metric_t win_ring [WIN_DEPTH];
	int unsigned ring_fill = 0;
	logic [5:0] ring_next = '0;
	metric_t cur_best = BEST_RESET;
	step_t cur_best_step = '0;
	stall_t cur_stall = '0;
	logic [MARGIN_W-1:0] cur_margin = '0;
	logic [WLEN_W-1:0] cur_wlen = '0;

	tracker_result_t pending_results [$];
	tracker_result_t oldest_want;
	int unsigned failures = 0;
	int unsigned sent = 0;
	bit tail_quiet = 0;
	stim_row_t plan [26];

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		#4000000;
		$display("Some tests failed");
		$finish;
	end

	function automatic tracker_result_t track_eval(step_t st, metric_t m);
		tracker_result_t r;
		logic gained;
		longint slope_sum;
		int n;
		logic [5:0] slot;
		gained = longint'(m) < longint'(cur_best) - longint'(cur_margin);
		if (gained) begin
			cur_best = m;
			cur_best_step = st;
			cur_stall = '0;
		end else if (cur_stall != '1) begin
			cur_stall = cur_stall + 1'b1;
		end
		win_ring[ring_next] = m;
		ring_next = ring_next + 1'b1;
		if (ring_fill < WIN_DEPTH)
			ring_fill++;
		n = (cur_wlen > WIN_DEPTH) ? WIN_DEPTH : int'(cur_wlen);
		r.plateau_reached = 1'b0;
		if (n >= 2 && ring_fill >= n) begin
			slope_sum = 0;
			// oldest entry gets the most negative weight
			for (int i = 0; i < n; i++) begin
				slot = 6'(int'(ring_next) - n + i);
				slope_sum += longint'(2 * i - (n - 1)) * longint'(win_ring[slot]);
			end
			r.plateau_reached = (slope_sum >= 0);
		end
		r.new_best = gained;
		r.best_metric = cur_best;
		r.best_at_step = cur_best_step;
		r.evals_without_gain = cur_stall;
		return r;
	endfunction

	function automatic stim_row_t row_eval(step_t st, metric_t m);
		return '{kind: ROW_EVAL, idx: '0, data: '0, st: st, m: m, typed: 1'b0, want: '0};
	endfunction

	function automatic stim_row_t row_cfg(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] data);
		return '{kind: ROW_CFG, idx: idx, data: data, st: '0, m: '0, typed: 1'b0, want: '0};
	endfunction

	function automatic stim_row_t row_want(step_t st, metric_t m, logic pl, logic nb,
			metric_t best, step_t bstep, stall_t stall);
		return '{kind: ROW_EVAL, idx: '0, data: '0, st: st, m: m, typed: 1'b1,
			want: '{pl, nb, best, bstep, stall}};
	endfunction

	// offer one beat; the expectation is queued up front since the result cannot precede it
	task automatic offer(step_t st, metric_t m, logic typed, tracker_result_t want);
		tracker_result_t predicted;
		predicted = track_eval(st, m);
		pending_results.insert(pending_results.size(), typed ? want : predicted);
		if (!tail_quiet && $urandom_range(0, 4) == 0) begin
			ev_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		ev_ch.valid <= 1'b1;
		ev_ch.eval_step <= st;
		ev_ch.metric_value <= m;
		do @(posedge clk); while (!ev_ch.ready);
		sent++;
	endtask

	task automatic settle();
		ev_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_IMPROVE_MARGIN: cur_margin = data[MARGIN_W-1:0];
			REG_WINDOW_LENGTH: begin
				cur_wlen = data[WLEN_W-1:0];
				ring_fill = 0;
				ring_next = '0;
			end
			default: ;
		endcase
		@(posedge clk);
	endtask

	// result sink with random stalls and one long hold-off
	initial begin
		int rounds;
		rounds = 0;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			rounds++;
			if (rounds == 120) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!tail_quiet && $urandom_range(0, 2) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected");
				failures++;
			end else begin
				oldest_want = pending_results.pop_front();
				if (res_ch.plateau_reached !== oldest_want.plateau_reached) begin
					$error("plateau_reached: expected %0b, got %0b",
						oldest_want.plateau_reached, res_ch.plateau_reached);
					failures++;
				end
				if (res_ch.new_best !== oldest_want.new_best) begin
					$error("new_best: expected %0b, got %0b",
						oldest_want.new_best, res_ch.new_best);
					failures++;
				end
				if (res_ch.best_metric !== oldest_want.best_metric) begin
					$error("best_metric: expected %0d, got %0d",
						oldest_want.best_metric, res_ch.best_metric);
					failures++;
				end
				if (res_ch.best_at_step !== oldest_want.best_at_step) begin
					$error("best_at_step: expected %0d, got %0d",
						oldest_want.best_at_step, res_ch.best_at_step);
					failures++;
				end
				if (res_ch.evals_without_gain !== oldest_want.evals_without_gain) begin
					$error("evals_without_gain: expected %0d, got %0d",
						oldest_want.evals_without_gain, res_ch.evals_without_gain);
					failures++;
				end
			end
		end
	end

	initial begin
		int n_items;
		int n_eff;
		int shape;
		int k;
		int ph;
		int pick;
		longint lvl;
		longint noisy;
		logic [WLEN_W-1:0] wl;
		logic [CFG_DATA_W-1:0] mg;
		step_t st_ctr;
		metric_t m;

		arst_n <= 1'b0;
		ev_ch.valid <= 1'b0;
		ev_ch.eval_step <= '0;
		ev_ch.metric_value <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		foreach (win_ring[i])
			win_ring[i] = '0;

		plan = '{
			row_want(32'd0, 32'sh7FFFFFFF, 1'b0, 1'b0, 32'sh7FFFFFFF, 32'd0, 32'd1),
			row_want(32'hFFFFFFFF, 32'sh7FFFFFFE, 1'b0, 1'b1, 32'sh7FFFFFFE,
				32'hFFFFFFFF, 32'd0),
			row_cfg(REG_SPARE_A, 31'h7FFFFFFF),
			row_cfg(REG_SPARE_B, 31'h7FFFFFFF),
			row_want(32'd1, 32'sh7FFFFFFD, 1'b0, 1'b1, 32'sh7FFFFFFD, 32'd1, 32'd0),
			row_want(32'd2, -32'sd2, 1'b0, 1'b1, -32'sd2, 32'd2, 32'd0),
			// best minus margin drops below the metric range
			row_cfg(REG_IMPROVE_MARGIN, 31'h7FFFFFFF),
			row_want(32'd3, 32'sh80000000, 1'b0, 1'b0, -32'sd2, 32'd2, 32'd1),
			// single-point window, upper data bits ignored
			row_cfg(REG_WINDOW_LENGTH, 31'h7FFFFF81),
			row_want(32'd4, 32'sh7FFFFFFF, 1'b0, 1'b0, -32'sd2, 32'd2, 32'd2),
			row_want(32'd5, 32'sh7FFFFFFF, 1'b0, 1'b0, -32'sd2, 32'd2, 32'd3),
			row_cfg(REG_WINDOW_LENGTH, 31'd2),
			row_eval(32'd6, 32'sh00010000),
			row_want(32'd7, 32'sh00010000, 1'b1, 1'b0, -32'sd2, 32'd2, 32'd5),
			row_eval(32'd8, 32'sd0),
			// rewriting the window restarts the fill
			row_cfg(REG_WINDOW_LENGTH, 31'd2),
			row_eval(32'd9, 32'sh7FFFFFFF),
			row_eval(32'd10, 32'sh7FFFFFFF),
			row_cfg(REG_WINDOW_LENGTH, 31'd3),
			row_eval(32'd11, 32'sh80000000),
			row_eval(32'd12, 32'sh7FFFFFFF),
			row_eval(32'd13, 32'sh7FFFFFFF),
			row_cfg(REG_IMPROVE_MARGIN, 31'd0),
			row_want(32'd14, -32'sd3, 1'b0, 1'b1, -32'sd3, 32'd14, 32'd0),
			row_cfg(REG_WINDOW_LENGTH, 31'h7FFFFF80),
			row_want(32'd15, 32'sd0, 1'b0, 1'b0, -32'sd3, 32'd14, 32'd1)
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(plan); i++) begin
			if (plan[i].kind == ROW_CFG) begin
				settle();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				offer(plan[i].st, plan[i].m, plan[i].typed, plan[i].want);
			end
		end

		st_ctr = 32'd16;
		ph = 0;
		while (sent < ITEM_GOAL) begin
			settle();
			pick = (ph == 0) ? 10 : (ph == 1) ? 11 : $urandom_range(0, 9);
			case (pick)
				0, 1, 2, 3: wl = WLEN_W'(pick);
				4, 5, 6, 7: wl = WLEN_W'($urandom_range(4, 16));
				8: wl = WLEN_W'($urandom_range(17, 63));
				9: wl = WLEN_W'($urandom_range(65, 126));
				10: wl = WLEN_W'(WIN_DEPTH);
				default: wl = '1;
			endcase
			n_eff = (wl > WIN_DEPTH) ? WIN_DEPTH : int'(wl);
			case ($urandom_range(0, 9))
				0: mg = '0;
				1: mg = '1;
				2, 3: mg = CFG_DATA_W'($urandom());
				default: mg = CFG_DATA_W'($urandom_range(0, 1 << 20));
			endcase
			write_reg(REG_IMPROVE_MARGIN, mg);
			write_reg(REG_WINDOW_LENGTH, {24'($urandom()), wl});
			if ($urandom_range(0, 3) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
					CFG_DATA_W'($urandom()));

			n_items = 2 * n_eff + $urandom_range(10, 40);
			shape = $urandom_range(0, 3);
			lvl = longint'(cur_best) + longint'($urandom_range(0, 1 << 18));
			repeat (n_items) begin
				if (sent >= ITEM_GOAL - QUIET_TAIL)
					tail_quiet = 1'b1;
				st_ctr = ($urandom_range(0, 19) == 0) ? step_t'($urandom())
					: st_ctr + step_t'($urandom_range(1, 500));
				// training-like curve: falling, flat or rising around the best so far
				case ((shape == 3) ? $urandom_range(0, 2) : shape)
					0: lvl -= longint'($urandom_range(0, 1 << 21));
					2: lvl += longint'($urandom_range(0, 1 << 16));
					default: ;
				endcase
				if (lvl < -64'sd2147483648)
					lvl = -64'sd2147483648;
				k = $urandom_range(0, 16);
				noisy = lvl + longint'($urandom_range(0, 1 << k)) - longint'((1 << k) >> 1);
				if (noisy < -64'sd2147483648)
					noisy = -64'sd2147483648;
				else if (noisy > 64'sd2147483647)
					noisy = 64'sd2147483647;
				m = metric_t'(noisy);
				// stray non-negative metric, never a gain at this point
				if ($urandom_range(0, 9) == 0)
					m = {1'b0, 31'($urandom())};
				offer(st_ctr, m, 1'b0, '0);
			end
			ph++;
		end

		settle();
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
+incdir+design
design/ptrk_pkg.sv
design/ptrk_if.sv
design/plateau_and_best_tracker_unit.sv
design/ptrk_checker.sv
dv/tb_plateau_and_best_tracker_unit.sv
